[rtl/core/voice_slot_manager_macros.svh]
// Assertion macros shared by the voice slot manager RTL.
`ifndef VOICE_SLOT_MANAGER_MACROS_SVH
`define VOICE_SLOT_MANAGER_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define VSM_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside reset.
`define VSM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/core/vsm_pkg.sv]
// Types, constants and codes shared by the voice slot manager modules.
package vsm_pkg;

	localparam int SLOTS      = 16;
	localparam int FRAME_BITS = 24;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int MASK_SLOTS = 16;
	localparam int COUNT_W    = 5;
	localparam int LEN_IN_W   = 24;

	typedef enum logic [2:0] {
		ACT_START   = 3'd0,
		ACT_RELEASE = 3'd1,
		ACT_PAUSE   = 3'd2,
		ACT_RESUME  = 3'd3,
		ACT_TICK    = 3'd4,
		ACT_QUERY   = 3'd5
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_OP,
		ST_TICK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic                  active;
		logic                  user_rel;
		logic                  player_rel;
		logic                  loops;
		logic [FRAME_BITS-1:0] length;
		logic [FRAME_BITS-1:0] position;
	} slot_entry_t;

	localparam slot_entry_t ENTRY_RESET = '{
		active:     1'b0,
		user_rel:   1'b1,
		player_rel: 1'b1,
		loops:      1'b0,
		length:     '0,
		position:   '0
	};

	typedef struct packed {
		logic [SLOT_W-1:0] raddr;
		logic              we;
		logic [SLOT_W-1:0] waddr;
		slot_entry_t       wdata;
	} ram_req_t;

	typedef struct packed {
		logic                  push;
		logic                  accepted;
		logic [3:0]            granted;
		logic [COUNT_W-1:0]    count;
		logic [MASK_SLOTS-1:0] mask;
		logic                  done;
	} ctrl_res_t;

endpackage

[rtl/core/voice_slot_manager.sv]
// Top level of the voice slot manager: sequencer, slot memory and result register.
//
// Keeps a table of 16 voice slots in a slot memory with one read port and one
// write port. For start, release, pause, resume and query the slot entry is read
// at the accepting edge, the ST_OP state modifies and writes it back and the
// ST_FINISH state hands the result over to the output register. A frame tick
// walks the slots one per cycle through the same memory. The next item is
// accepted in the cycle after the previous result is registered, so no item is
// taken while another is in work, while that result may still wait on the output
// side; a result held there stalls the hand-over of the next one. Per-entry
// valid bits give the reset state at once; no clearing pass follows reset.
`include "voice_slot_manager_macros.svh"

module voice_slot_manager (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    action,
	input  logic [3:0]                    slot,
	input  logic [vsm_pkg::LEN_IN_W-1:0]  sound_length,
	input  logic                          loop_enable,
	input  logic                          release_now,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          accepted,
	output logic [3:0]                    granted_slot,
	output logic [vsm_pkg::COUNT_W-1:0]   active_count,
	output logic [vsm_pkg::MASK_SLOTS-1:0] finished_mask,
	output logic                          done_res
);
	import vsm_pkg::*;

	ram_req_t    ram_req;
	slot_entry_t rd_data;
	ctrl_res_t   ctrl_res;
	logic        out_ready;
	logic        out_valid_q;

	vsm_slot_ram u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (ram_req),
		.rd_data (rd_data)
	);

	vsm_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.action       (action),
		.slot         (slot),
		.sound_length (sound_length),
		.loop_enable  (loop_enable),
		.release_now  (release_now),
		.rd_data      (rd_data),
		.ram_req      (ram_req),
		.out_ready    (out_ready),
		.res          (ctrl_res)
	);

	assign out_ready = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl_res.push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_res.push) begin
			accepted      <= ctrl_res.accepted;
			granted_slot  <= ctrl_res.granted;
			active_count  <= ctrl_res.count;
			finished_mask <= ctrl_res.mask;
			done_res      <= ctrl_res.done;
		end
	end

	assign out_valid = out_valid_q;

	`VSM_ASSERT_IMPL(a_push_room, ctrl_res.push, !out_valid_q || !out_stall, "result pushed over a held result")
	`VSM_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall, "item accepted while another is in work")
	`VSM_ASSERT_NEXT(a_push_shows, ctrl_res.push, out_valid_q, "pushed result not presented")
	`VSM_ASSERT_IMPL(a_done_alone, out_valid_q && done_res, active_count == '0 && finished_mask == '0, "query result carries tick fields")

endmodule

[rtl/core/vsm_slot_ram.sv]
// Slot state memory: one write port, one registered read port, per-entry valid bits.
module vsm_slot_ram (
	input  logic                 clk,
	input  logic                 arst_n,
	input  vsm_pkg::ram_req_t    req,
	output vsm_pkg::slot_entry_t rd_data
);
	import vsm_pkg::*;

	slot_entry_t             mem [SLOTS];
	logic        [SLOTS-1:0] valid_q;
	slot_entry_t             rd_q;
	logic                    rd_valid_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		rd_q <= mem[req.raddr];
	end

	// Entries never written read back as the reset slot state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr] <= 1'b1;
			end
			rd_valid_q <= valid_q[req.raddr];
		end
	end

	assign rd_data = rd_valid_q ? rd_q : ENTRY_RESET;

endmodule

[rtl/core/vsm_ctrl.sv]
// Sequencer: decodes an item, reads, modifies and writes back slot entries.
module vsm_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [2:0]                    action,
	input  logic [3:0]                    slot,
	input  logic [vsm_pkg::LEN_IN_W-1:0]  sound_length,
	input  logic                          loop_enable,
	input  logic                          release_now,
	input  vsm_pkg::slot_entry_t          rd_data,
	output vsm_pkg::ram_req_t             ram_req,
	input  logic                          out_ready,
	output vsm_pkg::ctrl_res_t            res
);
	import vsm_pkg::*;

	state_t                  state_q, state_d;
	action_t                 act_q, act_d;
	logic [3:0]              slot_q, slot_d;
	logic [FRAME_BITS-1:0]   len_q, len_d;
	logic                    loop_q, loop_d;
	logic                    now_q, now_d;
	logic [SLOT_W-1:0]       cnt_q, cnt_d;
	logic [COUNT_W-1:0]      count_q, count_d;
	logic [MASK_SLOTS-1:0]   mask_q, mask_d;
	logic                    acc_q, acc_d;
	logic [3:0]              gnt_q, gnt_d;
	logic                    done_q, done_d;
	logic [SLOTS-1:0]        free_q, free_d;

	logic                    found;
	logic [SLOT_W-1:0]       first_free;
	logic                    slot_ok;
	logic [SLOT_W-1:0]       slot_idx;
	logic                    slot_busy;
	logic [FRAME_BITS-1:0]   pos_inc;
	logic                    fin;
	logic                    playing;
	slot_entry_t             entry;

	// Lowest-numbered free slot.
	always_comb begin
		found      = 1'b0;
		first_free = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				found      = 1'b1;
				first_free = SLOT_W'(i);
			end
		end
	end

	assign slot_ok   = (32'(slot_q) < SLOTS);
	assign slot_idx  = SLOT_W'(slot_q);
	assign slot_busy = !(rd_data.user_rel && rd_data.player_rel);
	assign pos_inc   = rd_data.position + FRAME_BITS'(1);

	always_comb begin
		state_d = state_q;
		act_d   = act_q;
		slot_d  = slot_q;
		len_d   = len_q;
		loop_d  = loop_q;
		now_d   = now_q;
		cnt_d   = cnt_q;
		count_d = count_q;
		mask_d  = mask_q;
		acc_d   = acc_q;
		gnt_d   = gnt_q;
		done_d  = done_q;
		free_d  = free_q;
		entry   = rd_data;
		fin     = 1'b0;
		playing = 1'b0;

		in_stall      = (state_q != ST_IDLE);
		ram_req.raddr = cnt_q + SLOT_W'(1);
		ram_req.we    = 1'b0;
		ram_req.waddr = cnt_q;
		ram_req.wdata = rd_data;
		res.push      = 1'b0;
		res.accepted  = acc_q;
		res.granted   = gnt_q;
		res.count     = (act_q == ACT_TICK) ? count_q : '0;
		res.mask      = (act_q == ACT_TICK) ? mask_q : '0;
		res.done      = done_q;

		case (state_q)
			ST_IDLE: begin
				ram_req.raddr = (action_t'(action) == ACT_TICK) ? '0 : SLOT_W'(slot);
				if (in_valid) begin
					act_d   = action_t'(action);
					slot_d  = slot;
					len_d   = FRAME_BITS'(sound_length);
					loop_d  = loop_enable;
					now_d   = release_now;
					acc_d   = 1'b1;
					gnt_d   = slot;
					count_d = '0;
					mask_d  = '0;
					done_d  = 1'b0;
					cnt_d   = '0;
					state_d = (action_t'(action) == ACT_TICK) ? ST_TICK : ST_OP;
				end
			end
			ST_OP: begin
				ram_req.waddr = slot_idx;
				case (act_q)
					ACT_START: begin
						if (found) begin
							entry.active     = 1'b1;
							entry.user_rel   = 1'b0;
							entry.player_rel = 1'b0;
							entry.loops      = loop_q;
							entry.length     = len_q;
							entry.position   = '0;
							ram_req.we       = 1'b1;
							ram_req.waddr    = first_free;
							gnt_d            = 4'(first_free);
						end else begin
							acc_d = 1'b0;
						end
					end
					ACT_RELEASE: begin
						if (slot_ok) begin
							entry.user_rel = 1'b1;
							if (now_q) begin
								entry.active = 1'b0;
							end
							ram_req.we = 1'b1;
						end
					end
					ACT_PAUSE: begin
						if (slot_ok && slot_busy) begin
							entry.active = 1'b0;
							ram_req.we   = 1'b1;
						end
					end
					ACT_RESUME: begin
						if (slot_ok && slot_busy) begin
							entry.active = 1'b1;
							ram_req.we   = 1'b1;
						end
					end
					ACT_QUERY: begin
						if (slot_ok) begin
							done_d = rd_data.player_rel;
						end
					end
					default: begin
					end
				endcase
				ram_req.wdata = entry;
				state_d       = ST_FINISH;
			end
			ST_TICK: begin
				if (rd_data.active) begin
					if (pos_inc >= rd_data.length) begin
						entry.position = '0;
						if (rd_data.loops) begin
							playing = 1'b1;
						end else begin
							entry.active     = 1'b0;
							entry.player_rel = 1'b1;
							fin              = 1'b1;
						end
					end else begin
						entry.position = pos_inc;
						playing        = 1'b1;
					end
				end else if (rd_data.user_rel && !rd_data.player_rel) begin
					entry.player_rel = 1'b1;
					fin              = 1'b1;
				end
				if (playing && (count_q != {COUNT_W{1'b1}})) begin
					count_d = count_q + COUNT_W'(1);
				end
				if (fin && (32'(cnt_q) < MASK_SLOTS)) begin
					mask_d = mask_q | (MASK_SLOTS'(1) << 4'(cnt_q));
				end
				ram_req.we    = 1'b1;
				ram_req.wdata = entry;
				if (cnt_q == SLOT_W'(SLOTS - 1)) begin
					state_d = ST_FINISH;
				end else begin
					cnt_d = cnt_q + SLOT_W'(1);
				end
			end
			ST_FINISH: begin
				// Hold until the output register can take the result.
				res.push = out_ready;
				if (out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (ram_req.we) begin
			free_d[ram_req.waddr] = ram_req.wdata.user_rel && ram_req.wdata.player_rel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			free_q  <= '1;
		end else begin
			state_q <= state_d;
			free_q  <= free_d;
		end
	end

	always_ff @(posedge clk) begin
		act_q   <= act_d;
		slot_q  <= slot_d;
		len_q   <= len_d;
		loop_q  <= loop_d;
		now_q   <= now_d;
		cnt_q   <= cnt_d;
		count_q <= count_d;
		mask_q  <= mask_d;
		acc_q   <= acc_d;
		gnt_q   <= gnt_d;
		done_q  <= done_d;
	end

endmodule
